// ----- rtl/core/stream_duplicate_filter_assert.svh -----
// Assertion macros shared by the duplicate filter RTL.
`ifndef STREAM_DUPLICATE_FILTER_ASSERT_SVH
`define STREAM_DUPLICATE_FILTER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SDF_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define SDF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/sdf_pkg.sv -----
// Shared types and constants for the duplicate filter.
`default_nettype none

package sdf_pkg;

	localparam int unsigned VALUE_W = 64;
	localparam int unsigned UCOUNT_W = 7;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic scan;
		logic commit;
	} sdf_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic scan_done;
		logic slot_free;
	} sdf_sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/sdf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sdf_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                                     clk,
	input  wire logic                                     wr_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]                         wr_data,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic      [WIDTH-1:0]                         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

// ----- rtl/core/sdf_ctrl.sv -----
// Controller state machine for the duplicate filter.
`default_nettype none

module sdf_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	output sdf_pkg::sdf_cmd_t     cmd,
	input  wire sdf_pkg::sdf_sts_t sts
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	logic state_q;
	logic state_d;

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		cmd.load   = 1'b0;
		cmd.scan   = 1'b0;
		cmd.commit = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				// The result may only leave once the output register is free.
				if (sts.scan_done && sts.slot_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/sdf_dp.sv -----
// Datapath: input register, table scan, count and output register.
`default_nettype none

module sdf_dp #(
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [sdf_pkg::VALUE_W-1:0]   value,
	input  wire logic                          last,
	input  wire sdf_pkg::sdf_cmd_t             cmd,
	output sdf_pkg::sdf_sts_t                  sts,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic      [sdf_pkg::VALUE_W-1:0]   value_out,
	output logic                               keep,
	output logic                               overflow,
	output logic      [sdf_pkg::UCOUNT_W-1:0]  unique_count,
	output logic                               last_out
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [sdf_pkg::VALUE_W-1:0] value_q;
	logic                        last_q;
	logic [CW-1:0]               count_q;
	logic [CW-1:0]               rd_idx_q;
	logic                        pend_s1;
	logic                        hit_q;
	logic                        out_valid_q;

	logic [sdf_pkg::VALUE_W-1:0] rd_data;
	logic                        match;
	logic                        issue;
	logic                        full;
	logic                        store;
	logic [CW-1:0]               new_count;

	assign match = pend_s1 && (rd_data == value_q);
	// Stop fetching once every stored entry is requested or a match is seen.
	assign issue = cmd.scan && (rd_idx_q != count_q) && !hit_q && !match;
	assign full  = (count_q == FULL_CNT);
	assign store = cmd.commit && !hit_q && !full;
	assign new_count = store ? count_q + CW'(1) : count_q;

	assign sts.scan_done = !pend_s1 && (hit_q || (rd_idx_q == count_q));
	assign sts.slot_free = !out_valid_q || out_ready;

	sdf_ram #(
		.WIDTH(sdf_pkg::VALUE_W),
		.DEPTH(DEPTH)
	) u_table (
		.clk    (clk),
		.wr_en  (store),
		.wr_addr(count_q[AW-1:0]),
		.wr_data(value_q),
		.rd_addr(rd_idx_q[AW-1:0]),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			value_q <= value;
			last_q  <= last;
		end
		if (cmd.commit) begin
			value_out    <= value_q;
			keep         <= !hit_q;
			overflow     <= !hit_q && full;
			unique_count <= sdf_pkg::UCOUNT_W'(new_count);
			last_out     <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rd_idx_q    <= '0;
			pend_s1     <= 1'b0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				rd_idx_q <= '0;
				hit_q    <= 1'b0;
				pend_s1  <= 1'b0;
			end else begin
				pend_s1 <= issue;
				if (issue) begin
					rd_idx_q <= rd_idx_q + CW'(1);
				end
				if (match) begin
					hit_q <= 1'b1;
				end
			end
			if (cmd.commit) begin
				count_q <= last_q ? '0 : new_count;
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ----- rtl/core/stream_duplicate_filter.sv -----
// Each accepted item is scanned against the N distinct values stored in the current set;
// a match ends the scan early. Items are taken one at a time: the next is accepted only
// after the result of the last is committed. The single read port of the table memory
// limits the scan, as stored entries are compared one per cycle.
// A waiting result does not stop the next item being accepted and scanned.
// Reset (arst_n low) empties the table count and drops any item in flight.
`default_nettype none

`include "stream_duplicate_filter_assert.svh"

module stream_duplicate_filter #(
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [sdf_pkg::VALUE_W-1:0]  value,
	input  wire logic                         last,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic      [sdf_pkg::VALUE_W-1:0]  value_out,
	output logic                              keep,
	output logic                              overflow,
	output logic      [sdf_pkg::UCOUNT_W-1:0] unique_count,
	output logic                              last_out
);

	sdf_pkg::sdf_cmd_t cmd;
	sdf_pkg::sdf_sts_t sts;

	sdf_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd     (cmd),
		.sts     (sts)
	);

	sdf_dp #(
		.DEPTH(DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.value       (value),
		.last        (last),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.value_out   (value_out),
		.keep        (keep),
		.overflow    (overflow),
		.unique_count(unique_count),
		.last_out    (last_out)
	);

	`SDF_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "item accepted during scan")
	`SDF_ASSERT_SAME(a_ovf_keep, out_valid && overflow, keep, "overflow flagged on a repeat")
	`SDF_ASSERT_SAME(a_commit_slot, cmd.commit, sts.slot_free && !cmd.load, "result overwritten")
	`SDF_ASSERT_NEXT(a_commit_out, cmd.commit, out_valid, "committed result not presented")

endmodule

`default_nettype wire
